FILE: rtl/core/alu816_pkg.sv
`timescale 1ns / 1ps

package alu816_pkg;

   // Operation codes carried in the mode field.
   localparam logic [3:0] MODE_ADD    = 4'd0;
   localparam logic [3:0] MODE_ADC    = 4'd1;
   localparam logic [3:0] MODE_SUB    = 4'd2;
   localparam logic [3:0] MODE_SBC    = 4'd3;
   localparam logic [3:0] MODE_AND    = 4'd4;
   localparam logic [3:0] MODE_OR     = 4'd5;
   localparam logic [3:0] MODE_XOR    = 4'd6;
   localparam logic [3:0] MODE_CP     = 4'd7;
   localparam logic [3:0] MODE_INC    = 4'd8;
   localparam logic [3:0] MODE_DEC    = 4'd9;
   localparam logic [3:0] MODE_ADD16  = 4'd10;
   localparam logic [3:0] MODE_ADD16S = 4'd11;
   localparam logic [3:0] MODE_INC16  = 4'd12;
   localparam logic [3:0] MODE_DEC16  = 4'd13;

   // Bit positions inside the flag nibble.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   typedef struct packed {
      logic [3:0]  mode;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [3:0]  flags_in;
   } req_word_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
   } rsp_word_type;

endpackage

FILE: rtl/core/alu816_exec.sv
`timescale 1ns / 1ps

module alu816_exec (
   input  alu816_pkg::req_word_type op,
   output alu816_pkg::rsp_word_type res
);

   logic [7:0]  a8;
   logic [7:0]  b8;
   logic        cin;
   logic [8:0]  sum9;
   logic [4:0]  sum5;
   logic [8:0]  dif9;
   logic [4:0]  dif5;
   logic [7:0]  logic8;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic [15:0] bext;
   logic [8:0]  usum9;
   logic [4:0]  usum5;
   logic [15:0] result;
   logic [3:0]  flags;

   assign a8 = op.operand_a[7:0];
   assign b8 = op.operand_b[7:0];

   always_comb begin
      // Carry only enters for adc and sbc.
      cin = ((op.mode == alu816_pkg::MODE_ADC) || (op.mode == alu816_pkg::MODE_SBC))
            ? op.flags_in[alu816_pkg::FLAG_C] : 1'b0;

      sum9  = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
      sum5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
      dif9  = {1'b0, a8} - {1'b0, b8} - {8'd0, cin};
      dif5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin};
      sum17 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
      sum13 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
      bext  = {{8{b8[7]}}, b8};
      usum9 = {1'b0, a8} + {1'b0, b8};
      usum5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};

      case (op.mode)
         alu816_pkg::MODE_AND: logic8 = a8 & b8;
         alu816_pkg::MODE_OR:  logic8 = a8 | b8;
         default:              logic8 = a8 ^ b8;
      endcase

      result = op.operand_a;
      flags  = op.flags_in;

      case (op.mode)
         alu816_pkg::MODE_ADD, alu816_pkg::MODE_ADC: begin
            result = {8'd0, sum9[7:0]};
            flags[alu816_pkg::FLAG_Z] = (sum9[7:0] == 8'd0);
            flags[alu816_pkg::FLAG_N] = 1'b0;
            flags[alu816_pkg::FLAG_H] = sum5[4];
            flags[alu816_pkg::FLAG_C] = sum9[8];
         end
         alu816_pkg::MODE_SUB, alu816_pkg::MODE_SBC, alu816_pkg::MODE_CP: begin
            // Compare sets the flags but leaves the register alone.
            if (op.mode != alu816_pkg::MODE_CP) begin
               result = {8'd0, dif9[7:0]};
            end
            flags[alu816_pkg::FLAG_Z] = (dif9[7:0] == 8'd0);
            flags[alu816_pkg::FLAG_N] = 1'b1;
            flags[alu816_pkg::FLAG_H] = dif5[4];
            flags[alu816_pkg::FLAG_C] = dif9[8];
         end
         alu816_pkg::MODE_AND, alu816_pkg::MODE_OR, alu816_pkg::MODE_XOR: begin
            result = {8'd0, logic8};
            flags[alu816_pkg::FLAG_Z] = (logic8 == 8'd0);
            flags[alu816_pkg::FLAG_N] = 1'b0;
            flags[alu816_pkg::FLAG_H] = (op.mode == alu816_pkg::MODE_AND);
            flags[alu816_pkg::FLAG_C] = 1'b0;
         end
         alu816_pkg::MODE_INC: begin
            result = {8'd0, a8 + 8'd1};
            flags[alu816_pkg::FLAG_Z] = (a8 == 8'hFF);
            flags[alu816_pkg::FLAG_N] = 1'b0;
            flags[alu816_pkg::FLAG_H] = (a8[3:0] == 4'hF);
         end
         alu816_pkg::MODE_DEC: begin
            result = {8'd0, a8 - 8'd1};
            flags[alu816_pkg::FLAG_Z] = (a8 == 8'h01);
            flags[alu816_pkg::FLAG_N] = 1'b1;
            flags[alu816_pkg::FLAG_H] = (a8[3:0] == 4'h0);
         end
         alu816_pkg::MODE_ADD16: begin
            result = sum17[15:0];
            flags[alu816_pkg::FLAG_N] = 1'b0;
            flags[alu816_pkg::FLAG_H] = sum13[12];
            flags[alu816_pkg::FLAG_C] = sum17[16];
         end
         alu816_pkg::MODE_ADD16S: begin
            // Flags come from the unsigned add of the low bytes.
            result = op.operand_a + bext;
            flags[alu816_pkg::FLAG_Z] = 1'b0;
            flags[alu816_pkg::FLAG_N] = 1'b0;
            flags[alu816_pkg::FLAG_H] = usum5[4];
            flags[alu816_pkg::FLAG_C] = usum9[8];
         end
         alu816_pkg::MODE_INC16: begin
            result = op.operand_a + 16'd1;
         end
         alu816_pkg::MODE_DEC16: begin
            result = op.operand_a - 16'd1;
         end
         default: begin
            result = op.operand_a;
            flags  = op.flags_in;
         end
      endcase
   end

   assign res.result    = result;
   assign res.flags_out = flags;

endmodule

FILE: rtl/core/alu_with_flags_8_16_bit_core.sv
`timescale 1ns / 1ps
// An accepted request word passes through the input register, then the result
// register, before its response word is offered on rsp_word.
// Throughput: one word per cycle; req_stall rises only when both registers
// are full and rsp_stall is high.
// Reset clears both valid flags; payload registers are not reset.

module alu_with_flags_8_16_bit_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  alu816_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output alu816_pkg::rsp_word_type rsp_word
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   alu816_pkg::req_word_type in_word_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   alu816_pkg::rsp_word_type out_word_ff;
   alu816_pkg::rsp_word_type exec_word;
   logic                     out_free;
   logic                     in_move;
   logic                     req_take;

   alu816_exec u_exec (
      .op  (in_word_ff),
      .res (exec_word)
   );

   // The result register frees up when empty or when its word is taken.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = in_move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (in_move) begin
         out_word_ff <= exec_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

FILE: bench/tb_alu_with_flags_8_16_bit_core.sv
`timescale 1ns / 1ps

module tb_alu_with_flags_8_16_bit_core;

   // The package names only the defined modes; the two spare codes must echo operand A and the input flags.
   localparam logic [3:0] MODE_SPARE_LO = 4'd14;
   localparam logic [3:0] MODE_SPARE_HI = 4'd15;
   localparam int RANDOM_WORDS = 1750;

   typedef struct packed {
      alu816_pkg::req_word_type w;
      logic                     known;
      alu816_pkg::rsp_word_type exp;
   } table_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   alu816_pkg::req_word_type req_word = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   alu816_pkg::rsp_word_type rsp_word;

   alu816_pkg::rsp_word_type expected_rsp[$];
   table_row_type            directed[$];
   int unsigned              mismatches = 0;
   int unsigned              stall_left = 0;
   int unsigned              cycle_count = 0;
   bit                       rsp_calm = 1'b0;
   bit                       req_burst = 1'b0;

   alu_with_flags_8_16_bit_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic alu816_pkg::rsp_word_type alu_predict(alu816_pkg::req_word_type w);
      alu816_pkg::rsp_word_type r;
      logic [7:0]   a;
      logic [7:0]   b;
      logic [8:0]   wide8;
      logic [4:0]   nib;
      logic [16:0]  wide16;
      logic [12:0]  wide12;
      logic         cin;
      logic [3:0]   f;
      logic [15:0]  res;
      a = w.operand_a[7:0];
      b = w.operand_b[7:0];
      f = w.flags_in;
      res = w.operand_a;
      cin = (w.mode == alu816_pkg::MODE_ADC || w.mode == alu816_pkg::MODE_SBC)
            ? f[alu816_pkg::FLAG_C] : 1'b0;
      case (w.mode)
         alu816_pkg::MODE_ADD, alu816_pkg::MODE_ADC: begin
            wide8 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
            nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
            res = {8'h00, wide8[7:0]};
            f[alu816_pkg::FLAG_Z] = (wide8[7:0] == 8'h00);
            f[alu816_pkg::FLAG_N] = 1'b0;
            f[alu816_pkg::FLAG_H] = nib[4];
            f[alu816_pkg::FLAG_C] = wide8[8];
         end
         alu816_pkg::MODE_SUB, alu816_pkg::MODE_SBC, alu816_pkg::MODE_CP: begin
            // Bit 8 and bit 4 of the widened differences are the borrows.
            wide8 = {1'b0, a} - {1'b0, b} - {8'h00, cin};
            nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};
            res = (w.mode == alu816_pkg::MODE_CP) ? w.operand_a : {8'h00, wide8[7:0]};
            f[alu816_pkg::FLAG_Z] = (wide8[7:0] == 8'h00);
            f[alu816_pkg::FLAG_N] = 1'b1;
            f[alu816_pkg::FLAG_H] = nib[4];
            f[alu816_pkg::FLAG_C] = wide8[8];
         end
         alu816_pkg::MODE_AND, alu816_pkg::MODE_OR, alu816_pkg::MODE_XOR: begin
            if (w.mode == alu816_pkg::MODE_AND) begin
               res = {8'h00, a & b};
            end else if (w.mode == alu816_pkg::MODE_OR) begin
               res = {8'h00, a | b};
            end else begin
               res = {8'h00, a ^ b};
            end
            f[alu816_pkg::FLAG_Z] = (res == 16'h0000);
            f[alu816_pkg::FLAG_N] = 1'b0;
            f[alu816_pkg::FLAG_H] = (w.mode == alu816_pkg::MODE_AND);
            f[alu816_pkg::FLAG_C] = 1'b0;
         end
         alu816_pkg::MODE_INC: begin
            res = {8'h00, a + 8'h01};
            f[alu816_pkg::FLAG_Z] = (res == 16'h0000);
            f[alu816_pkg::FLAG_N] = 1'b0;
            f[alu816_pkg::FLAG_H] = (a[3:0] == 4'hF);
         end
         alu816_pkg::MODE_DEC: begin
            res = {8'h00, a - 8'h01};
            f[alu816_pkg::FLAG_Z] = (res == 16'h0000);
            f[alu816_pkg::FLAG_N] = 1'b1;
            f[alu816_pkg::FLAG_H] = (a[3:0] == 4'h0);
         end
         alu816_pkg::MODE_ADD16: begin
            wide16 = {1'b0, w.operand_a} + {1'b0, w.operand_b};
            wide12 = {1'b0, w.operand_a[11:0]} + {1'b0, w.operand_b[11:0]};
            res = wide16[15:0];
            f[alu816_pkg::FLAG_N] = 1'b0;
            f[alu816_pkg::FLAG_H] = wide12[12];
            f[alu816_pkg::FLAG_C] = wide16[16];
         end
         alu816_pkg::MODE_ADD16S: begin
            // Flags come from the unsigned sum of the low bytes, not the 16-bit sum.
            wide8 = {1'b0, a} + {1'b0, b};
            nib = {1'b0, a[3:0]} + {1'b0, b[3:0]};
            res = w.operand_a + {{8{b[7]}}, b};
            f[alu816_pkg::FLAG_Z] = 1'b0;
            f[alu816_pkg::FLAG_N] = 1'b0;
            f[alu816_pkg::FLAG_H] = nib[4];
            f[alu816_pkg::FLAG_C] = wide8[8];
         end
         alu816_pkg::MODE_INC16: res = w.operand_a + 16'h0001;
         alu816_pkg::MODE_DEC16: res = w.operand_a - 16'h0001;
         default: ;
      endcase
      r.result = res;
      r.flags_out = f;
      return r;
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 96) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_operand();
      logic [15:0] v;
      v = 16'($urandom);
      case ($urandom_range(0, 9))
         0: v = 16'h0000;
         1: v = 16'hFFFF;
         2: v[7:0] = 8'hFF;
         3: v[7:0] = 8'h00;
         4: v[7:0] = 8'h80;
         5: v[7:0] = 8'h7F;
         6: v[11:0] = 12'hFFF;
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_row(input logic [3:0] m, input logic [15:0] a, input logic [15:0] b,
                          input logic [3:0] f, input logic known,
                          input logic [15:0] res, input logic [3:0] fo);
      table_row_type row;
      row.w.mode = m;
      row.w.operand_a = a;
      row.w.operand_b = b;
      row.w.flags_in = f;
      row.known = known;
      row.exp.result = res;
      row.exp.flags_out = fo;
      directed.push_back(row);
   endtask

   // Holds the word until the block takes it, then records what should come back.
   task automatic send_word(input alu816_pkg::req_word_type w,
                            input alu816_pkg::rsp_word_type exp);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(exp);
   endtask

   task automatic hold_off(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 0) begin
         rsp_calm <= ($urandom_range(0, 3) == 0);
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!rsp_calm && $urandom_range(0, 3) == 0) begin
         stall_left <= idle_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_check
      alu816_pkg::rsp_word_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
               $display("unexpected response word: result %h flags %b",
                        rsp_word.result, rsp_word.flags_out);
            end
         end else begin
            exp = expected_rsp.pop_front();
            if (rsp_word.result !== exp.result || rsp_word.flags_out !== exp.flags_out) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) begin
                  $display("mismatch: expected result %h flags %b, got result %h flags %b",
                           exp.result, exp.flags_out, rsp_word.result, rsp_word.flags_out);
               end
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      alu816_pkg::req_word_type w;
      table_row_type            row;

      // Corners of each mode; flag nibbles read Z N H C.
      add_row(alu816_pkg::MODE_ADD,    16'h00FF, 16'h0001, 4'b0000, 1'b1, 16'h0000, 4'b1011);
      add_row(alu816_pkg::MODE_ADD,    16'h0000, 16'h0000, 4'b1111, 1'b1, 16'h0000, 4'b1000);
      add_row(alu816_pkg::MODE_ADC,    16'h00FF, 16'h00FF, 4'b0001, 1'b1, 16'h00FF, 4'b0011);
      add_row(alu816_pkg::MODE_ADC,    16'hFFFF, 16'hFFFF, 4'b0000, 1'b0, '0, '0);
      add_row(alu816_pkg::MODE_SUB,    16'h0000, 16'h0001, 4'b0000, 1'b1, 16'h00FF, 4'b0111);
      add_row(alu816_pkg::MODE_SUB,    16'h0042, 16'h0042, 4'b0000, 1'b1, 16'h0000, 4'b1100);
      add_row(alu816_pkg::MODE_SBC,    16'h0000, 16'h00FF, 4'b0001, 1'b1, 16'h0000, 4'b1111);
      add_row(alu816_pkg::MODE_SBC,    16'h1280, 16'h0000, 4'b0001, 1'b0, '0, '0);
      add_row(alu816_pkg::MODE_CP,     16'hABCD, 16'h00CD, 4'b0000, 1'b1, 16'hABCD, 4'b1100);
      add_row(alu816_pkg::MODE_CP,     16'h0000, 16'hFFFF, 4'b1111, 1'b0, '0, '0);
      add_row(alu816_pkg::MODE_AND,    16'hFFFF, 16'h0000, 4'b1111, 1'b1, 16'h0000, 4'b1010);
      add_row(alu816_pkg::MODE_AND,    16'hFFFF, 16'hFFFF, 4'b0000, 1'b1, 16'h00FF, 4'b0010);
      add_row(alu816_pkg::MODE_OR,     16'h0000, 16'h0000, 4'b1111, 1'b1, 16'h0000, 4'b1000);
      add_row(alu816_pkg::MODE_XOR,    16'h00FF, 16'hFFFF, 4'b1111, 1'b1, 16'h0000, 4'b1000);
      add_row(alu816_pkg::MODE_INC,    16'h00FF, 16'h0000, 4'b0000, 1'b1, 16'h0000, 4'b1010);
      add_row(alu816_pkg::MODE_INC,    16'hFF0F, 16'h5555, 4'b0001, 1'b0, '0, '0);
      add_row(alu816_pkg::MODE_DEC,    16'h0001, 16'h0000, 4'b0000, 1'b1, 16'h0000, 4'b1100);
      add_row(alu816_pkg::MODE_DEC,    16'h0000, 16'hFFFF, 4'b1111, 1'b1, 16'h00FF, 4'b0111);
      add_row(alu816_pkg::MODE_ADD16,  16'hFFFF, 16'h0001, 4'b1000, 1'b1, 16'h0000, 4'b1011);
      add_row(alu816_pkg::MODE_ADD16,  16'h0FFF, 16'h0001, 4'b0000, 1'b0, '0, '0);
      add_row(alu816_pkg::MODE_ADD16S, 16'h0000, 16'h00FF, 4'b1111, 1'b1, 16'hFFFF, 4'b0000);
      add_row(alu816_pkg::MODE_ADD16S, 16'hFFFF, 16'h0001, 4'b0000, 1'b1, 16'h0000, 4'b0011);
      add_row(alu816_pkg::MODE_ADD16S, 16'h1234, 16'hFF7F, 4'b1010, 1'b0, '0, '0);
      add_row(alu816_pkg::MODE_INC16,  16'hFFFF, 16'h0000, 4'b0101, 1'b1, 16'h0000, 4'b0101);
      add_row(alu816_pkg::MODE_DEC16,  16'h0000, 16'hFFFF, 4'b1010, 1'b1, 16'hFFFF, 4'b1010);
      add_row(MODE_SPARE_LO,           16'hBEEF, 16'h1234, 4'b0110, 1'b1, 16'hBEEF, 4'b0110);
      add_row(MODE_SPARE_HI,           16'h8001, 16'hFFFF, 4'b1001, 1'b0, '0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         row = directed[i];
         send_word(row.w, row.known ? row.exp : alu_predict(row.w));
         if (i % 3 == 2) begin
            hold_off(idle_len());
         end
      end
      drain_all();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 128 == 0) begin
            req_burst = ($urandom_range(0, 2) == 0);
         end
         if (i % 400 == 399) begin
            drain_all();
         end
         if ($urandom_range(0, 19) == 0) begin
            w.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
         end else begin
            w.mode = 4'($urandom_range(alu816_pkg::MODE_ADD, alu816_pkg::MODE_DEC16));
         end
         w.operand_a = pick_operand();
         w.operand_b = pick_operand();
         w.flags_in = 4'($urandom_range(0, 15));
         send_word(w, alu_predict(w));
         if (!req_burst && $urandom_range(0, 1) == 0) begin
            hold_off(idle_len());
         end
      end

      drain_all();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
